// ----- hdl/iad_pkg.sv -----
// Package for the integer to decimal ASCII converter.
// Holds shared constants and the back-end state type; no dependencies.
`default_nettype none

package iad_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int Q_DEPTH        = 2;

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_MINUS = 8'd45;

  typedef enum logic [1:0] {
    B_IDLE,
    B_CONV,
    B_SIGN,
    B_DIGIT
  } back_state_t;

endpackage

`default_nettype wire

// ----- hdl/iad_front.sv -----
// Front end: accepts an input value and splits it into sign and magnitude.
// Depends on nothing outside this file; feeds iad_fifo.
`default_nettype none

module iad_front #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic [VALUE_BITS-1:0] in_value,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  output logic                       push_valid,
  input  wire logic                  push_ready,
  output logic [VALUE_BITS:0]        push_data
);

  logic                  negative;
  logic [VALUE_BITS-1:0] magnitude;

  // Two's-complement negate in an unsigned word; the most negative value
  // maps to 2^(VALUE_BITS-1), which fits.
  assign negative  = in_value[VALUE_BITS-1];
  assign magnitude = negative ? (~in_value + 1'b1) : in_value;

  assign push_valid = in_valid;
  assign in_ready   = push_ready;
  assign push_data  = {negative, magnitude};

endmodule

`default_nettype wire

// ----- hdl/iad_fifo.sv -----
// Short queue between the front end and the converter back end.
// Uses iad_pkg for its depth.
`default_nettype none

module iad_fifo #(
  parameter int WIDTH = 33
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic [WIDTH-1:0]      pop_data
);

  localparam int DEPTH = iad_pkg::Q_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/iad_back.sv -----
// Back end: bit-serial binary to BCD conversion, then character emission.
// Uses iad_pkg for the ASCII codes and the state type.
`default_nettype none

module iad_back #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                pop_valid,
  output logic                     pop_ready,
  input  wire logic [VALUE_BITS:0] pop_data,
  output logic [7:0]               out_text_char,
  output logic                     out_last_char,
  output logic                     out_valid,
  input  wire logic                out_ready
);

  // Decimal digits of the largest magnitude (floor(N*log10(2)) + 1).
  localparam int NDIG = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int BW   = 4 * NDIG;
  localparam int IW   = $clog2(NDIG);
  localparam int CW   = $clog2(NDIG + 1);
  localparam int SW   = $clog2(VALUE_BITS);

  iad_pkg::back_state_t state_r, state_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [7:0]            char_r, char_nxt;
  logic                  last_r, last_nxt;
  logic [VALUE_BITS-1:0] mag_r, mag_nxt;
  logic                  neg_r, neg_nxt;
  logic [BW-1:0]         bcd_r, bcd_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [IW-1:0]         idx_r, idx_nxt;
  logic [SW-1:0]         step_r, step_nxt;

  logic [BW-1:0]         bcd_adj;
  logic [BW-1:0]         bcd_shift;
  logic [3:0]            nib_chk;
  logic [CW-1:0]         cnt_new;
  logic [3:0]            nib_out;
  logic                  slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign nib_out   = bcd_r[idx_r*4 +: 4];

  // One double-dabble step: correct each digit, then shift in the next bit.
  always_comb begin
    bcd_adj = bcd_r;
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_r[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd_r[i*4 +: 4] + 4'd3;
      end
    end
    bcd_shift = {bcd_adj[BW-2:0], mag_r[VALUE_BITS-1]};
    // Significant digits grow by at most one per step; watch the next one.
    if (cnt_r < CW'(NDIG)) begin
      nib_chk = bcd_shift[cnt_r[IW-1:0]*4 +: 4];
    end else begin
      nib_chk = 4'd0;
    end
    cnt_new = (nib_chk != 4'd0) ? cnt_r + 1'b1 : cnt_r;
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    char_nxt      = char_r;
    last_nxt      = last_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    bcd_nxt       = bcd_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    step_nxt      = step_r;
    pop_ready     = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      iad_pkg::B_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          neg_nxt   = pop_data[VALUE_BITS];
          mag_nxt   = pop_data[VALUE_BITS-1:0];
          bcd_nxt   = '0;
          cnt_nxt   = '0;
          step_nxt  = SW'(VALUE_BITS - 1);
          state_nxt = iad_pkg::B_CONV;
        end
      end
      iad_pkg::B_CONV: begin
        bcd_nxt = bcd_shift;
        mag_nxt = {mag_r[VALUE_BITS-2:0], 1'b0};
        cnt_nxt = cnt_new;
        if (step_r == '0) begin
          // Zero still prints one digit.
          idx_nxt   = (cnt_new == '0) ? '0 : IW'(cnt_new - 1'b1);
          state_nxt = neg_r ? iad_pkg::B_SIGN : iad_pkg::B_DIGIT;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      iad_pkg::B_SIGN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          char_nxt      = iad_pkg::ASCII_MINUS;
          last_nxt      = 1'b0;
          state_nxt     = iad_pkg::B_DIGIT;
        end
      end
      iad_pkg::B_DIGIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          char_nxt      = iad_pkg::ASCII_ZERO + {4'd0, nib_out};
          last_nxt      = (idx_r == '0);
          if (idx_r == '0) begin
            state_nxt = iad_pkg::B_IDLE;
          end else begin
            idx_nxt = idx_r - 1'b1;
          end
        end
      end
      default: state_nxt = iad_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= iad_pkg::B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
    last_r <= last_nxt;
    mag_r  <= mag_nxt;
    neg_r  <= neg_nxt;
    bcd_r  <= bcd_nxt;
    cnt_r  <= cnt_nxt;
    idx_r  <= idx_nxt;
    step_r <= step_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_text_char = char_r;
  assign out_last_char = last_r;

  // A shown character is a minus sign or a decimal digit.
  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (char_r == iad_pkg::ASCII_MINUS) ||
                    ((char_r >= iad_pkg::ASCII_ZERO) &&
                     (char_r <= iad_pkg::ASCII_ZERO + 8'd9)))
    else $error("illegal output character");

  // The sign never ends a value's text.
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (char_r == iad_pkg::ASCII_MINUS)) |-> !last_r)
    else $error("minus sign flagged last");

  // Conversion leaves after its final step.
  a_conv_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == iad_pkg::B_CONV && step_r == '0) |=> (state_r != iad_pkg::B_CONV))
    else $error("conversion overran its step count");

  // No new item is taken while a conversion or emission is in progress.
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop_ready |-> (state_r == iad_pkg::B_IDLE))
    else $error("queue popped outside idle");

endmodule

`default_nettype wire

// ----- hdl/int_to_decimal_ascii_core.sv -----
// Signed integer to decimal ASCII converter, one character per transfer.
// The first character is registered after the queue, the B_IDLE pop and the B_CONV steps.
// Throughput is set by the bit-serial double-dabble loop in the back end (one input bit
//   per cycle); the back end takes a new value only after the last one's final character.
// Reset (rst_n, synchronous, active low) empties the queue and drops any result in flight.
// Depends on iad_pkg, iad_front, iad_fifo and iad_back.
`default_nettype none

module int_to_decimal_ascii_core #(
  parameter int VALUE_BITS = iad_pkg::VALUE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Input channel: one signed value per transfer.
  input  wire logic [VALUE_BITS-1:0] in_value,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  // Result channel: one ASCII character per transfer, last_char on the final one.
  output logic [7:0]                 out_text_char,
  output logic                       out_last_char,
  output logic                       out_valid,
  input  wire logic                  out_ready
);

  // Queue entries carry the sign on top of the magnitude.
  logic                  push_valid;
  logic                  push_ready;
  logic [VALUE_BITS:0]   push_data;
  logic                  pop_valid;
  logic                  pop_ready;
  logic [VALUE_BITS:0]   pop_data;

  // Front: classify sign and take the magnitude in an unsigned word.
  iad_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .in_value   (in_value),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Queue: lets the front take a new value while the back is still emitting.
  iad_fifo #(
    .WIDTH (VALUE_BITS + 1)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Back: convert to BCD, skip leading zeros, emit sign then digits through
  // an output register so the back can advance while a character waits.
  iad_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_data      (pop_data),
    .out_text_char (out_text_char),
    .out_last_char (out_last_char),
    .out_valid     (out_valid),
    .out_ready     (out_ready)
  );

endmodule

`default_nettype wire
